>>> sv/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// shared widths, register indexes, reset values and frame layout of the
// dcf77 time code decoder
// ----------------------------------------------------------------------------
`default_nettype none

package dcf_pkg;

  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int COUNT_W_DEF    = 16;

  localparam int IN_DATA_W      = 8;
  localparam int OUT_DATA_W     = 16;
  localparam int OUT_USER_W     = 2;
  localparam int HOURS_W        = 5;
  localparam int MINUTES_W      = 6;

  localparam int FRAME_BITS     = 59;
  localparam int BIT_IDX_W      = 6;
  localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(58);

  localparam logic [CFG_IDX_W-1:0] REG_GLITCH_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAP      = 2'd2;

  localparam logic [CFG_W-1:0] GLITCH_LIMIT_RST  = 16'd40;
  localparam logic [CFG_W-1:0] ONE_THRESHOLD_RST = 16'd150;
  localparam logic [CFG_W-1:0] SYNC_GAP_RST      = 16'd1000;

  localparam logic [5:0] HOUR_MAX   = 6'd23;
  localparam logic [6:0] MINUTE_MAX = 7'd59;

  // output tuser bit positions
  localparam int USER_MINUTE_START = 0;
  localparam int USER_TIME_LOADED  = 1;

endpackage

`default_nettype wire

>>> sv/dcf77_time_code_decoder_core.sv
// ----------------------------------------------------------------------------
// dcf77_time_code_decoder_core
// dcf77 minute frame decoder: pulse timing, bit capture and hour/minute decode
// ----------------------------------------------------------------------------
// One receiver sample per input beat, one result beat per input beat. A beat
// is taken in every cycle while the output register is empty or being drained,
// so the sustained rate is one sample per clock; the result is registered and
// appears in the cycle after its sample. The only stall comes from the output
// register when the downstream side holds off out_tready. Configuration writes
// are always ready and take effect on the next sample.
`default_nettype none

module dcf77_time_code_decoder_core #(
  parameter int COUNT_WIDTH = dcf_pkg::COUNT_W_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // bit 0: signal_level
  input  wire  [dcf_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // bits 4:0 hours, 10:5 minutes
  output logic [dcf_pkg::OUT_DATA_W-1:0]     out_tdata,
  // bit 0 minute_start, bit 1 time_loaded
  output logic [dcf_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [dcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [dcf_pkg::CFG_W-1:0]          cfg_data
);

  localparam int CMP_W = (COUNT_WIDTH > dcf_pkg::CFG_W) ? COUNT_WIDTH : dcf_pkg::CFG_W;

  logic [dcf_pkg::CFG_W-1:0]         glitch_r, one_r, gap_r;
  logic [COUNT_WIDTH-1:0]            tick_r, tick_nxt, tick_inc;
  logic                              high_r, high_nxt;
  logic                              fvalid_r, fvalid_nxt;
  logic                              pend_r, pend_nxt;
  logic [dcf_pkg::BIT_IDX_W-1:0]     bidx_r, bidx_nxt, idx;
  logic [dcf_pkg::FRAME_BITS-1:0]    store_r, store_nxt;
  logic [dcf_pkg::OUT_DATA_W-1:0]    odata_r, odata_nxt;
  logic [dcf_pkg::OUT_USER_W-1:0]    ouser_r, ouser_nxt;
  logic                              ovalid_r;

  logic                              level, in_acc;
  logic [CMP_W-1:0]                  tick_cmp;
  logic [5:0]                        hv;
  logic [6:0]                        mv;
  logic                              frame_ok, start, loaded;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = !ovalid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign level     = in_tdata[0];

  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tvalid = ovalid_r;

  // frame checks on the stored bits
  always_comb begin
    hv = 6'(store_r[32:29]) + (store_r[33] ? 6'd10 : 6'd0) + (store_r[34] ? 6'd20 : 6'd0);
    mv = 7'(store_r[24:21]) + (store_r[25] ? 7'd10 : 7'd0) + (store_r[26] ? 7'd20 : 7'd0)
       + (store_r[27] ? 7'd40 : 7'd0);
    frame_ok = fvalid_r && !store_r[0] && !(^store_r[28:21]) && !(^store_r[35:29])
            && !(^store_r[58:36]) && (hv <= dcf_pkg::HOUR_MAX) && (mv <= dcf_pkg::MINUTE_MAX);
  end

  always_comb begin
    tick_inc   = (tick_r != {COUNT_WIDTH{1'b1}}) ? tick_r + 1'b1 : tick_r;
    tick_cmp   = CMP_W'(tick_inc);
    tick_nxt   = tick_inc;
    high_nxt   = high_r;
    fvalid_nxt = fvalid_r;
    pend_nxt   = pend_r;
    bidx_nxt   = bidx_r;
    store_nxt  = store_r;
    idx        = (bidx_r > dcf_pkg::LAST_BIT) ? dcf_pkg::LAST_BIT : bidx_r;
    start      = 1'b0;
    loaded     = 1'b0;

    // minute gap
    if (!fvalid_r && !high_r && !level && (tick_cmp > CMP_W'(gap_r))) begin
      fvalid_nxt = 1'b1;
      bidx_nxt   = '0;
      pend_nxt   = 1'b1;
    end

    if (high_r && !level) begin
      high_nxt = 1'b0;
      if (fvalid_r) begin
        if (tick_cmp < CMP_W'(glitch_r)) begin
          fvalid_nxt = 1'b0;
        end else if (tick_cmp >= CMP_W'(one_r)) begin
          store_nxt[idx] = 1'b1;
        end else begin
          store_nxt[idx] = 1'b0;
        end
        if (idx >= dcf_pkg::LAST_BIT) begin
          fvalid_nxt = 1'b0;
          bidx_nxt   = dcf_pkg::LAST_BIT;
        end else begin
          bidx_nxt = idx + 1'b1;
        end
      end
      tick_nxt = '0;
    end else if (!high_r && level) begin
      if (pend_r) begin
        start    = 1'b1;
        loaded   = frame_ok;
        pend_nxt = 1'b0;
      end
      high_nxt = 1'b1;
      tick_nxt = '0;
    end

    odata_nxt = '0;
    if (loaded) begin
      odata_nxt[dcf_pkg::HOURS_W-1:0] = hv[dcf_pkg::HOURS_W-1:0];
      odata_nxt[dcf_pkg::HOURS_W+dcf_pkg::MINUTES_W-1:dcf_pkg::HOURS_W] =
        mv[dcf_pkg::MINUTES_W-1:0];
    end
    ouser_nxt = '0;
    ouser_nxt[dcf_pkg::USER_MINUTE_START] = start;
    ouser_nxt[dcf_pkg::USER_TIME_LOADED]  = loaded;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glitch_r <= dcf_pkg::GLITCH_LIMIT_RST;
      one_r    <= dcf_pkg::ONE_THRESHOLD_RST;
      gap_r    <= dcf_pkg::SYNC_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dcf_pkg::REG_GLITCH_LIMIT:  glitch_r <= cfg_data;
        dcf_pkg::REG_ONE_THRESHOLD: one_r    <= cfg_data;
        dcf_pkg::REG_SYNC_GAP:      gap_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      high_r   <= 1'b0;
      fvalid_r <= 1'b0;
      pend_r   <= 1'b0;
      bidx_r   <= '0;
      store_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        tick_r   <= tick_nxt;
        high_r   <= high_nxt;
        fvalid_r <= fvalid_nxt;
        pend_r   <= pend_nxt;
        bidx_r   <= bidx_nxt;
        store_r  <= store_nxt;
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      odata_r <= odata_nxt;
      ouser_r <= ouser_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/dcf_core_chk.sv
// ----------------------------------------------------------------------------
// dcf_core_chk
// port level checks of the dcf77 time code decoder core
// ----------------------------------------------------------------------------
`default_nettype none

module dcf_core_chk (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire [dcf_pkg::OUT_DATA_W-1:0]    out_tdata,
  input wire [dcf_pkg::OUT_USER_W-1:0]    out_tuser,
  input wire                              out_tvalid,
  input wire                              out_tready
);

  // a loaded time only comes with a minute start
  a_load_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[dcf_pkg::USER_TIME_LOADED]
      |-> out_tuser[dcf_pkg::USER_MINUTE_START])
    else $error("time_loaded without minute_start");

  // no time, no payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[dcf_pkg::USER_TIME_LOADED] |-> out_tdata == '0)
    else $error("payload set without time_loaded");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[dcf_pkg::USER_TIME_LOADED]
      |-> out_tdata[4:0] <= 5'd23 && out_tdata[10:5] <= 6'd59)
    else $error("decoded time out of range");

  // every sample gives a result beat
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("sample without result beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

endmodule

bind dcf77_time_code_decoder_core dcf_core_chk u_dcf_core_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

>>> verif/tb_dcf77_time_code_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_dcf77_time_code_decoder_core
// self-checking bench for the dcf77 minute frame decoder. A scoreboard class
// mirrors the pulse timing, bit capture and hour/minute decode per sample and
// checks every result beat in order. Stimulus is a short directed sequence,
// phases at extreme thresholds and random minute frames (well formed, broken
// and noise) under changing timings, with bursty input, random output stalls
// and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dcf77_time_code_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct packed {
    logic                          start;
    logic                          loaded;
    logic [dcf_pkg::HOURS_W-1:0]   hours;
    logic [dcf_pkg::MINUTES_W-1:0] minutes;
  } minute_result_t;

  class minute_scoreboard;
    logic [dcf_pkg::CFG_W-1:0]       glitch_limit;
    logic [dcf_pkg::CFG_W-1:0]       one_threshold;
    logic [dcf_pkg::CFG_W-1:0]       sync_gap;
    logic [dcf_pkg::COUNT_W_DEF-1:0] tick_count;
    bit                              signal_high;
    bit                              frame_valid;
    bit                              minute_pending;
    logic [dcf_pkg::BIT_IDX_W-1:0]   bit_index;
    logic [dcf_pkg::FRAME_BITS-1:0]  bit_store;
    minute_result_t                  expected_q[$];
    int                              errors;
    int                              samples;
    int                              starts;
    int                              loads;
    int                              beats;

    function new();
      glitch_limit   = dcf_pkg::GLITCH_LIMIT_RST;
      one_threshold  = dcf_pkg::ONE_THRESHOLD_RST;
      sync_gap       = dcf_pkg::SYNC_GAP_RST;
      tick_count     = '0;
      signal_high    = 1'b0;
      frame_valid    = 1'b0;
      minute_pending = 1'b0;
      bit_index      = '0;
      bit_store      = '0;
      errors         = 0;
      samples        = 0;
      starts         = 0;
      loads          = 0;
      beats          = 0;
    endfunction

    function void set_reg(logic [dcf_pkg::CFG_IDX_W-1:0] idx, logic [dcf_pkg::CFG_W-1:0] val);
      case (idx)
        dcf_pkg::REG_GLITCH_LIMIT:  glitch_limit  = val;
        dcf_pkg::REG_ONE_THRESHOLD: one_threshold = val;
        dcf_pkg::REG_SYNC_GAP:      sync_gap      = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit decode_time(output logic [dcf_pkg::HOURS_W-1:0] h,
                             output logic [dcf_pkg::MINUTES_W-1:0] m);
      logic [5:0] hv;
      logic [6:0] mv;
      h = '0;
      m = '0;
      if (!frame_valid || bit_store[0]) return 1'b0;
      if (^bit_store[28:21] || ^bit_store[35:29] || ^bit_store[58:36]) return 1'b0;
      hv = 6'(bit_store[32:29]) + 6'(bit_store[34:33]) * 6'd10;
      mv = 7'(bit_store[24:21]) + 7'(bit_store[27:25]) * 7'd10;
      if (hv > dcf_pkg::HOUR_MAX || mv > dcf_pkg::MINUTE_MAX) return 1'b0;
      h = hv[dcf_pkg::HOURS_W-1:0];
      m = mv[dcf_pkg::MINUTES_W-1:0];
      return 1'b1;
    endfunction

    function void note_sample(bit lvl);
      minute_result_t                r;
      logic [dcf_pkg::BIT_IDX_W-1:0] idx;
      logic [dcf_pkg::HOURS_W-1:0]   h;
      logic [dcf_pkg::MINUTES_W-1:0] m;
      r = '0;
      samples++;
      if (tick_count != {dcf_pkg::COUNT_W_DEF{1'b1}}) tick_count++;
      if (!frame_valid && !signal_high && !lvl && tick_count > sync_gap) begin
        frame_valid    = 1'b1;
        bit_index      = '0;
        minute_pending = 1'b1;
      end
      if (signal_high && !lvl) begin
        signal_high = 1'b0;
        if (frame_valid) begin
          idx = (bit_index > dcf_pkg::LAST_BIT) ? dcf_pkg::LAST_BIT : bit_index;
          if (tick_count < glitch_limit) frame_valid = 1'b0;
          else if (tick_count >= one_threshold) bit_store[idx] = 1'b1;
          else bit_store[idx] = 1'b0;
          if (idx >= dcf_pkg::LAST_BIT) begin
            frame_valid = 1'b0;
            bit_index   = dcf_pkg::LAST_BIT;
          end else begin
            bit_index = idx + 1'b1;
          end
        end
        tick_count = '0;
      end else if (!signal_high && lvl) begin
        if (minute_pending) begin
          r.start  = 1'b1;
          r.loaded = decode_time(h, m);
          r.hours  = h;
          r.minutes = m;
          minute_pending = 1'b0;
          starts++;
          if (r.loaded) loads++;
        end
        signal_high = 1'b1;
        tick_count  = '0;
      end
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(logic [dcf_pkg::OUT_USER_W-1:0] user,
                      logic [dcf_pkg::OUT_DATA_W-1:0] data);
      minute_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat %0d arrived with nothing expected", beats));
        beats++;
        return;
      end
      e = expected_q.pop_front();
      if (user[dcf_pkg::USER_MINUTE_START] !== e.start)
        report($sformatf("beat %0d minute_start %b, expected %b", beats,
                         user[dcf_pkg::USER_MINUTE_START], e.start));
      if (user[dcf_pkg::USER_TIME_LOADED] !== e.loaded)
        report($sformatf("beat %0d time_loaded %b, expected %b", beats,
                         user[dcf_pkg::USER_TIME_LOADED], e.loaded));
      if (data[dcf_pkg::HOURS_W-1:0] !== e.hours)
        report($sformatf("beat %0d hours %0d, expected %0d", beats,
                         data[dcf_pkg::HOURS_W-1:0], e.hours));
      if (data[dcf_pkg::HOURS_W+dcf_pkg::MINUTES_W-1:dcf_pkg::HOURS_W] !== e.minutes)
        report($sformatf("beat %0d minutes %0d, expected %0d", beats,
                         data[dcf_pkg::HOURS_W+dcf_pkg::MINUTES_W-1:dcf_pkg::HOURS_W],
                         e.minutes));
      if (data[dcf_pkg::OUT_DATA_W-1:dcf_pkg::HOURS_W+dcf_pkg::MINUTES_W] !== '0)
        report($sformatf("beat %0d padding bits %b not zero", beats,
                         data[dcf_pkg::OUT_DATA_W-1:dcf_pkg::HOURS_W+dcf_pkg::MINUTES_W]));
      beats++;
    endtask
  endclass

  logic                           clk;
  logic                           rst_n;
  logic [dcf_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [dcf_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [dcf_pkg::OUT_USER_W-1:0] out_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [dcf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dcf_pkg::CFG_W-1:0]      cfg_data;

  minute_scoreboard sb;
  bit hold_req;
  int burst_left;
  int cur_glitch;
  int cur_one;
  int cur_gap;
  int cfg_writes;
  int idle_cycles;

  dcf77_time_code_decoder_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int span;
    int pct;
    out_tready <= 1'b0;
    forever begin
      span = $urandom_range(20, 200);
      case ($urandom_range(0, 3))
        0:       pct = 100;
        1:       pct = 80;
        2:       pct = 50;
        default: pct = 20;
      endcase
      repeat (span) begin
        @(posedge clk);
        if (hold_req) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_req = 1'b0;
        end else begin
          out_tready <= ($urandom_range(1, 100) <= pct);
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_level(bit lvl);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 30);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= dcf_pkg::IN_DATA_W'(lvl);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(lvl);
  endtask

  task automatic send_run(bit lvl, int n);
    repeat (n) send_level(lvl);
  endtask

  task automatic quiesce();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [dcf_pkg::CFG_IDX_W-1:0] idx, logic [dcf_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic set_timing(int g, int o, int s);
    quiesce();
    write_reg(dcf_pkg::REG_GLITCH_LIMIT, dcf_pkg::CFG_W'(g));
    write_reg(dcf_pkg::REG_ONE_THRESHOLD, dcf_pkg::CFG_W'(o));
    write_reg(dcf_pkg::REG_SYNC_GAP, dcf_pkg::CFG_W'(s));
    cfg_valid <= 1'b0;
    cur_glitch = g;
    cur_one    = o;
    cur_gap    = s;
  endtask

  task automatic pick_timing();
    int g;
    int o;
    int s;
    g = $urandom_range(0, 2);
    o = (g == 0) ? 2 : $urandom_range(g + 1, g + 2);
    s = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
    set_timing(g, o, s);
  endtask

  function automatic int pulse_len(bit is_one);
    if (is_one) return $urandom_range(cur_one, cur_one + 1);
    return $urandom_range((cur_glitch < 1) ? 1 : cur_glitch, cur_one - 1);
  endfunction

  function automatic logic [dcf_pkg::FRAME_BITS-1:0] build_frame(bit good);
    logic [dcf_pkg::FRAME_BITS-1:0] f;
    int mn;
    int hr;
    f  = dcf_pkg::FRAME_BITS'({$urandom, $urandom});
    mn = $urandom_range(0, 59);
    hr = $urandom_range(0, 23);
    f[24:21] = 4'(mn % 10);
    f[27:25] = 3'(mn / 10);
    f[32:29] = 4'(hr % 10);
    f[34:33] = 2'(hr / 10);
    f[0]  = 1'b0;
    f[28] = ^f[27:21];
    f[35] = ^f[34:29];
    f[58] = ^f[57:36];
    if (!good) begin
      case ($urandom_range(0, 5))
        0: f[0] = 1'b1;
        1: f[28] = ~f[28];
        2: f[35] = ~f[35];
        3: f[58] = ~f[58];
        4: begin
          f[27:25] = 3'd6;
          f[28] = ^f[27:21];
        end
        default: begin
          f[34:33] = 2'd3;
          f[35] = ^f[34:29];
        end
      endcase
    end
    return f;
  endfunction

  task automatic send_frame(logic [dcf_pkg::FRAME_BITS-1:0] f, bit broken);
    int last;
    int k;
    last = broken ? $urandom_range(1, 58) : 58;
    send_run(1'b0, cur_gap + 2 + $urandom_range(0, 2));
    for (k = 0; k <= last; k++) begin
      if (broken && k == last && cur_glitch >= 2)
        send_run(1'b1, $urandom_range(1, cur_glitch - 1));
      else
        send_run(1'b1, pulse_len(f[k]));
      send_run(1'b0, $urandom_range(1, 2));
    end
  endtask

  task automatic send_noise(int runs);
    repeat (runs) send_run(1'($urandom_range(0, 1)), $urandom_range(1, 4));
  endtask

  task automatic send_pulses(int n);
    send_run(1'b0, 5);
    repeat (n) begin
      send_run(1'b1, $urandom_range(1, 3));
      send_run(1'b0, $urandom_range(1, 6));
    end
  endtask

  initial begin
    int base;
    int sel;
    bit hold_done;
    sb         = new();
    hold_req   = 1'b0;
    burst_left = 0;
    cfg_writes = 0;
    cur_glitch = dcf_pkg::GLITCH_LIMIT_RST;
    cur_one    = dcf_pkg::ONE_THRESHOLD_RST;
    cur_gap    = dcf_pkg::SYNC_GAP_RST;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing, then tiny timing: sync, stale-store load, glitch, resync
    send_run(1'b0, 3);
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    set_timing(2, 3, 4);
    send_run(1'b0, 6);
    send_run(1'b1, 3);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 6);
    send_run(1'b1, 2);
    send_run(1'b0, 2);

    // threshold extremes
    set_timing(0, 65535, 0);
    send_pulses(20);
    set_timing(0, 0, 3);
    send_pulses(20);
    set_timing(65535, 0, 3);
    send_pulses(20);

    pick_timing();
    base = sb.samples;
    hold_done = 1'b0;
    while (sb.samples - base < RANDOM_ITEMS) begin
      if (!hold_done && sb.samples - base > RANDOM_ITEMS / 2) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      sel = $urandom_range(0, 9);
      if (sel < 6) send_frame(build_frame(1'b1), 1'b0);
      else if (sel < 8) send_frame(build_frame(1'b0), 1'($urandom_range(0, 1)));
      else send_noise($urandom_range(10, 40));
      if ($urandom_range(0, 3) == 0) pick_timing();
    end
    send_run(1'b0, cur_gap + 3);
    send_run(1'b1, 2);
    send_run(1'b0, 1);

    quiesce();
    repeat (8) @(posedge clk);
    $display("run covered %0d samples, %0d minute starts, %0d decoded times, %0d reg writes",
             sb.samples, sb.starts, sb.loads, cfg_writes);
    $display("timings ranged from single ticks to 16-bit extremes, with bursts and stalls");
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
